/* sv/shc_pkg.sv */
// ----------------------------------------------------------------------------
// shc_pkg
// Shared constants for the swept circle versus rectangle hit test.
// ----------------------------------------------------------------------------
package shc_pkg;

    // guard bits added to coordinates before differences and sums
    localparam int EXT_BITS    = 3;
    localparam int NUM_EDGES   = 4;
    localparam int NUM_CORNERS = 4;
    // pipeline depth from input register to output register
    localparam int STAGES      = 8;

endpackage

/* sv/shc_if.sv */
// ----------------------------------------------------------------------------
// shc_in_if / shc_out_if
// Valid/ready channels for hit test items and results.
// ----------------------------------------------------------------------------
interface shc_in_if #(
    parameter int N = 16
) ();
    logic                valid;
    logic                ready;
    logic signed [N-1:0] center_x;
    logic signed [N-1:0] center_y;
    logic        [N-2:0] circle_radius;
    logic signed [N-1:0] move_x;
    logic signed [N-1:0] move_y;
    logic signed [N-1:0] box_left;
    logic signed [N-1:0] box_top;
    logic        [N-2:0] box_width;
    logic        [N-2:0] box_height;

    modport source (
        output valid, center_x, center_y, circle_radius, move_x, move_y,
               box_left, box_top, box_width, box_height,
        input  ready
    );
    modport sink (
        input  valid, center_x, center_y, circle_radius, move_x, move_y,
               box_left, box_top, box_width, box_height,
        output ready
    );
endinterface

interface shc_out_if ();
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink (input valid, hit, output ready);
endinterface

/* sv/shc_sqmul.sv */
// ----------------------------------------------------------------------------
// shc_sqmul
// Two stage unsigned multiplier: registered half-width partial products,
// then a registered sum.
// ----------------------------------------------------------------------------
module shc_sqmul #(
    parameter int W = 38
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [W-1:0]   i_a,
    input  logic [W-1:0]   i_b,
    output logic [2*W-1:0] o_p
);
    localparam int H = (W + 1) / 2;

    logic [2*H-1:0] ea;
    logic [2*H-1:0] eb;
    logic [2*H-1:0] r_ll, r_lh, r_hl, r_hh;
    logic [2*H-1:0] n_ll, n_lh, n_hl, n_hh;
    logic [4*H-1:0] r_p;
    logic [4*H-1:0] n_p;

    assign ea = (2*H)'(i_a);
    assign eb = (2*H)'(i_b);

    always_comb begin
        n_ll = ea[H-1:0]   * eb[H-1:0];
        n_lh = ea[H-1:0]   * eb[2*H-1:H];
        n_hl = ea[2*H-1:H] * eb[H-1:0];
        n_hh = ea[2*H-1:H] * eb[2*H-1:H];
        n_p  = {r_hh, r_ll}
             + ((4*H)'(r_lh) << H)
             + ((4*H)'(r_hl) << H);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= n_ll;
            r_lh <= n_lh;
            r_hl <= n_hl;
            r_hh <= n_hh;
            r_p  <= n_p;
        end
    end

    assign o_p = r_p[2*W-1:0];
endmodule

/* sv/swept_circle_rect_hit.sv */
// ----------------------------------------------------------------------------
// swept_circle_rect_hit
// An accepted item passes the stage registers in order up to the output register.
// Throughput: one item per cycle; the whole pipeline holds while the output
// register waits to be taken.
// Reset: synchronous, clears the stage valid bits only.
// Tests start/end touch, edge crossings and corner sweeps of a moving circle.
// ----------------------------------------------------------------------------
module swept_circle_rect_hit #(
    parameter int COORD_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    shc_in_if.sink     i_in,
    shc_out_if.source  o_out
);
    localparam int N  = COORD_BITS;
    localparam int D  = N + shc_pkg::EXT_BITS;
    localparam int P  = 2 * D;
    localparam int S  = P + 1;
    localparam int NE = shc_pkg::NUM_EDGES;
    localparam int NC = shc_pkg::NUM_CORNERS;
    localparam int L  = shc_pkg::STAGES;

    logic         en;
    logic [L:1]   r_vld;

    // stage 1
    logic signed [D-1:0] r1_cx, r1_cy, r1_vx, r1_vy, r1_x0, r1_y0, r1_x1, r1_y1;
    logic signed [D-1:0] r1_ex, r1_ey, r1_r, r1_w, r1_h;
    // stage 2
    logic signed [D-1:0] r2_dsx, r2_dsy, r2_dex, r2_dey, r2_r, r2_vx, r2_vy;
    logic signed [D-1:0] r2_fx [2];
    logic signed [D-1:0] r2_fy [2];
    logic signed [D-1:0] r2_gap [NE];
    logic signed [D-1:0] r2_spd [NE];
    logic signed [D-1:0] r2_off [NE];
    logic signed [D-1:0] r2_vel [NE];
    logic signed [D-1:0] r2_spn [NE];
    logic [NE-1:0]       r2_een;
    logic                r2_vnz;
    logic signed [D-1:0] n2_dsx, n2_dsy, n2_dex, n2_dey;
    logic signed [D-1:0] n2_gap [NE];
    logic signed [D-1:0] n2_spd [NE];
    logic signed [D-1:0] n2_off [NE];
    logic signed [D-1:0] n2_vel [NE];
    logic signed [D-1:0] n2_spn [NE];
    logic [NE-1:0]       n2_een;
    // stage 3
    logic signed [P-1:0] r3_sxs, r3_sys, r3_sxe, r3_sye, r3_rr, r3_vxx, r3_vyy;
    logic signed [P-1:0] r3_ov [NE];
    logic signed [P-1:0] r3_vg [NE];
    logic signed [P-1:0] r3_ss [NE];
    logic [NE-1:0]       r3_een;
    logic signed [P-1:0] r3_fxvx [2];
    logic signed [P-1:0] r3_fxvy [2];
    logic signed [P-1:0] r3_fyvx [2];
    logic signed [P-1:0] r3_fyvy [2];
    logic                r3_vnz;
    // stage 4
    logic signed [S-1:0] r4_d2s, r4_d2e, r4_a;
    logic signed [P-1:0] r4_rr;
    logic signed [S-1:0] r4_pe [NE];
    logic signed [P-1:0] r4_ss [NE];
    logic [NE-1:0]       r4_een;
    logic signed [S-1:0] r4_g [NC];
    logic signed [S-1:0] r4_cr [NC];
    logic                r4_vnz;
    // stage 5
    logic                r5_pre;
    logic [NC-1:0]       r5_cen;
    logic [P-1:0]        r5_cabs [NC];
    logic [P-1:0]        r5_rr, r5_a;
    logic [NE-1:0]       n5_edge;
    logic [NC-1:0]       n5_cen;
    // stages 6, 7 (flags beside the multipliers)
    logic                r6_pre, r7_pre;
    logic [NC-1:0]       r6_cen, r7_cen;
    logic [2*P-1:0]      m_cc [NC];
    logic [2*P-1:0]      m_ra;
    // stage 8
    logic                r8_hit;
    logic [NC-1:0]       n8_chit;

    assign en         = !r_vld[L] || o_out.ready;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[L-1:1], i_in.valid};
        end
    end

    // stage 2 logic
    always_comb begin
        n2_dsx = (r1_cx < r1_x0) ? r1_cx - r1_x0 : ((r1_cx > r1_x1) ? r1_cx - r1_x1 : '0);
        n2_dsy = (r1_cy < r1_y0) ? r1_cy - r1_y0 : ((r1_cy > r1_y1) ? r1_cy - r1_y1 : '0);
        n2_dex = (r1_ex < r1_x0) ? r1_ex - r1_x0 : ((r1_ex > r1_x1) ? r1_ex - r1_x1 : '0);
        n2_dey = (r1_ey < r1_y0) ? r1_ey - r1_y0 : ((r1_ey > r1_y1) ? r1_ey - r1_y1 : '0);

        n2_gap[0] = r1_y0 - r1_cy - r1_r;
        n2_spd[0] = r1_vy;
        n2_off[0] = r1_cx - r1_x0;
        n2_vel[0] = r1_vx;
        n2_spn[0] = r1_w;
        n2_een[0] = (r1_vy > 0) && (n2_gap[0] >= 0);

        n2_gap[1] = r1_cy - r1_r - r1_y1;
        n2_spd[1] = -r1_vy;
        n2_off[1] = r1_cx - r1_x0;
        n2_vel[1] = r1_vx;
        n2_spn[1] = r1_w;
        n2_een[1] = (r1_vy < 0) && (n2_gap[1] >= 0);

        n2_gap[2] = r1_x0 - r1_cx - r1_r;
        n2_spd[2] = r1_vx;
        n2_off[2] = r1_cy - r1_y0;
        n2_vel[2] = r1_vy;
        n2_spn[2] = r1_h;
        n2_een[2] = (r1_vx > 0) && (n2_gap[2] >= 0);

        n2_gap[3] = r1_cx - r1_r - r1_x1;
        n2_spd[3] = -r1_vx;
        n2_off[3] = r1_cy - r1_y0;
        n2_vel[3] = r1_vy;
        n2_spn[3] = r1_h;
        n2_een[3] = (r1_vx < 0) && (n2_gap[3] >= 0);
    end

    // stage 5 logic
    always_comb begin
        for (int k = 0; k < NE; k++) begin
            n5_edge[k] = r4_een[k] && (r4_pe[k] >= 0) && (r4_pe[k] <= r4_ss[k]);
        end
        for (int k = 0; k < NC; k++) begin
            n5_cen[k] = r4_vnz && (r4_g[k] >= 0) && (r4_g[k] <= r4_a);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_cx <= {{shc_pkg::EXT_BITS{i_in.center_x[N-1]}}, i_in.center_x};
            r1_cy <= {{shc_pkg::EXT_BITS{i_in.center_y[N-1]}}, i_in.center_y};
            r1_vx <= {{shc_pkg::EXT_BITS{i_in.move_x[N-1]}}, i_in.move_x};
            r1_vy <= {{shc_pkg::EXT_BITS{i_in.move_y[N-1]}}, i_in.move_y};
            r1_x0 <= {{shc_pkg::EXT_BITS{i_in.box_left[N-1]}}, i_in.box_left};
            r1_y0 <= {{shc_pkg::EXT_BITS{i_in.box_top[N-1]}}, i_in.box_top};
            r1_x1 <= D'(i_in.box_left) + $signed(D'(i_in.box_width));
            r1_y1 <= D'(i_in.box_top) + $signed(D'(i_in.box_height));
            r1_ex <= D'(i_in.center_x) + D'(i_in.move_x);
            r1_ey <= D'(i_in.center_y) + D'(i_in.move_y);
            r1_r  <= $signed(D'(i_in.circle_radius));
            r1_w  <= $signed(D'(i_in.box_width));
            r1_h  <= $signed(D'(i_in.box_height));

            r2_dsx <= n2_dsx;
            r2_dsy <= n2_dsy;
            r2_dex <= n2_dex;
            r2_dey <= n2_dey;
            r2_r   <= r1_r;
            r2_vx  <= r1_vx;
            r2_vy  <= r1_vy;
            r2_fx[0] <= r1_cx - r1_x0;
            r2_fx[1] <= r1_cx - r1_x1;
            r2_fy[0] <= r1_cy - r1_y0;
            r2_fy[1] <= r1_cy - r1_y1;
            r2_gap <= n2_gap;
            r2_spd <= n2_spd;
            r2_off <= n2_off;
            r2_vel <= n2_vel;
            r2_spn <= n2_spn;
            r2_een <= n2_een;
            r2_vnz <= (r1_vx != 0) || (r1_vy != 0);

            r3_sxs <= r2_dsx * r2_dsx;
            r3_sys <= r2_dsy * r2_dsy;
            r3_sxe <= r2_dex * r2_dex;
            r3_sye <= r2_dey * r2_dey;
            r3_rr  <= r2_r * r2_r;
            r3_vxx <= r2_vx * r2_vx;
            r3_vyy <= r2_vy * r2_vy;
            for (int k = 0; k < NE; k++) begin
                r3_ov[k]  <= r2_off[k] * r2_spd[k];
                r3_vg[k]  <= r2_vel[k] * r2_gap[k];
                r3_ss[k]  <= r2_spn[k] * r2_spd[k];
                r3_een[k] <= r2_een[k] && (r2_gap[k] <= r2_spd[k]);
            end
            for (int j = 0; j < 2; j++) begin
                r3_fxvx[j] <= r2_fx[j] * r2_vx;
                r3_fxvy[j] <= r2_fx[j] * r2_vy;
                r3_fyvx[j] <= r2_fy[j] * r2_vx;
                r3_fyvy[j] <= r2_fy[j] * r2_vy;
            end
            r3_vnz <= r2_vnz;

            r4_d2s <= S'(r3_sxs) + S'(r3_sys);
            r4_d2e <= S'(r3_sxe) + S'(r3_sye);
            r4_a   <= S'(r3_vxx) + S'(r3_vyy);
            r4_rr  <= r3_rr;
            for (int k = 0; k < NE; k++) begin
                r4_pe[k] <= S'(r3_ov[k]) + S'(r3_vg[k]);
            end
            r4_ss  <= r3_ss;
            r4_een <= r3_een;
            for (int k = 0; k < NC; k++) begin
                r4_g[k]  <= -(S'(r3_fxvx[k % 2]) + S'(r3_fyvy[k / 2]));
                r4_cr[k] <= S'(r3_fxvy[k % 2]) - S'(r3_fyvx[k / 2]);
            end
            r4_vnz <= r3_vnz;

            r5_pre <= (r4_d2s <= r4_rr) || (r4_d2e <= r4_rr) || (|n5_edge);
            r5_cen <= n5_cen;
            for (int k = 0; k < NC; k++) begin
                r5_cabs[k] <= r4_cr[k][S-1] ? P'(-r4_cr[k]) : P'(r4_cr[k]);
            end
            r5_rr <= r4_rr;
            r5_a  <= P'(r4_a);

            r6_pre <= r5_pre;
            r6_cen <= r5_cen;
            r7_pre <= r6_pre;
            r7_cen <= r6_cen;

            r8_hit <= r7_pre || (|n8_chit);
        end
    end

    for (genvar k = 0; k < NC; k++) begin : g_corner
        shc_sqmul #(.W(P)) u_cc (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (r5_cabs[k]),
            .i_b   (r5_cabs[k]),
            .o_p   (m_cc[k])
        );
        assign n8_chit[k] = r7_cen[k] && (m_cc[k] <= m_ra);
    end

    shc_sqmul #(.W(P)) u_ra (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r5_rr),
        .i_b   (r5_a),
        .o_p   (m_ra)
    );

    assign o_out.valid = r_vld[L];
    assign o_out.hit   = r8_hit;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("stage valids moved during a stall");
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && i_in.valid) |=> r_vld[1])
        else $error("accepted item not captured in first stage");
    a_pre_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_vld[L-1] && r7_pre) |=> o_out.hit)
        else $error("position or edge hit lost at output");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");
endmodule

/* tb/swept_circle_rect_hit_tb.sv */
// ----------------------------------------------------------------------------
// swept_circle_rect_hit_tb
// Drives circle/rectangle items with random gaps and output stalls, predicts
// the hit flag with exact wide integer math and checks every result in order.
// ----------------------------------------------------------------------------
module swept_circle_rect_hit_tb;

    typedef struct packed {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [14:0]        r;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] x0;
        logic signed [15:0] y0;
        logic [14:0]        w;
        logic [14:0]        h;
    } t_sweep;

    typedef logic signed [127:0] t_wide;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    shc_in_if #(.N(16)) in_ch ();
    shc_out_if          out_ch ();

    swept_circle_rect_hit #(.COORD_BITS(16)) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always #1 i_clk = ~i_clk;

    t_sweep pending_items[$];
    logic   expected_hits[$];
    int     mismatches = 0;
    longint cycle_count = 0;
    bit     stim_done = 1'b0;
    int     in_wait = 0;
    int     out_wait = 0;

    function automatic t_wide clampw(t_wide v, t_wide lo, t_wide hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic bit touches_at(t_wide px, t_wide py, t_wide r,
                                      t_wide x0, t_wide y0, t_wide x1, t_wide y1);
        t_wide dx, dy;
        dx = px - clampw(px, x0, x1);
        dy = py - clampw(py, y0, y1);
        return dx * dx + dy * dy <= r * r;
    endfunction

    function automatic bit crosses_edge(t_wide gap, t_wide speed, t_wide off,
                                        t_wide vel, t_wide span);
        t_wide p;
        if (gap > speed) return 1'b0;
        p = off * speed + vel * gap;
        return p >= 0 && p <= span * speed;
    endfunction

    function automatic logic predict_hit(t_sweep s);
        t_wide cx, cy, r, vx, vy, x0, y0, x1, y1, a, g, c, fx, fy;
        bit hit;
        cx = s.cx; cy = s.cy; r = {113'd0, s.r};
        vx = s.vx; vy = s.vy; x0 = s.x0; y0 = s.y0;
        x1 = x0 + {113'd0, s.w};
        y1 = y0 + {113'd0, s.h};
        hit = touches_at(cx, cy, r, x0, y0, x1, y1)
           || touches_at(cx + vx, cy + vy, r, x0, y0, x1, y1);
        if (!hit && vy > 0 && cy + r <= y0)
            hit = crosses_edge(y0 - (cy + r), vy, cx - x0, vx, x1 - x0);
        if (!hit && vy < 0 && cy - r >= y1)
            hit = crosses_edge((cy - r) - y1, -vy, cx - x0, vx, x1 - x0);
        if (!hit && vx > 0 && cx + r <= x0)
            hit = crosses_edge(x0 - (cx + r), vx, cy - y0, vy, y1 - y0);
        if (!hit && vx < 0 && cx - r >= x1)
            hit = crosses_edge((cx - r) - x1, -vx, cy - y0, vy, y1 - y0);
        if (!hit && (vx != 0 || vy != 0)) begin
            a = vx * vx + vy * vy;
            for (int k = 0; k < shc_pkg::NUM_CORNERS && !hit; k++) begin
                fx = cx - (k[0] ? x1 : x0);
                fy = cy - (k[1] ? y1 : y0);
                g = -(fx * vx + fy * vy);
                c = fx * fx + fy * fy - r * r;
                if (g >= 0 && g <= a && g * g >= a * c) hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic [15:0] rnd16(bit near);
        if (near) return 16'($signed($urandom_range(0, 400)) - 200);
        return 16'($urandom);
    endfunction

    function automatic t_sweep random_sweep();
        t_sweep s;
        bit near;
        near = $urandom_range(0, 3) != 0;
        s.cx = rnd16(near); s.cy = rnd16(near);
        s.x0 = rnd16(near); s.y0 = rnd16(near);
        s.vx = $urandom_range(0, 5) == 0 ? 16'd0 : rnd16(near);
        s.vy = $urandom_range(0, 5) == 0 ? 16'd0 : rnd16(near);
        s.r  = near ? 15'($urandom_range(0, 60)) : 15'($urandom);
        s.w  = near ? 15'($urandom_range(0, 150)) : 15'($urandom);
        s.h  = near ? 15'($urandom_range(0, 150)) : 15'($urandom);
        if ($urandom_range(0, 9) == 0) s.r = 15'h7fff;
        return s;
    endfunction

    function automatic t_sweep mk(int cx, int cy, int r, int vx, int vy,
                                  int x0, int y0, int w, int h);
        t_sweep s;
        s.cx = 16'(cx); s.cy = 16'(cy); s.r = 15'(r);
        s.vx = 16'(vx); s.vy = 16'(vy);
        s.x0 = 16'(x0); s.y0 = 16'(y0); s.w = 15'(w); s.h = 15'(h);
        return s;
    endfunction

    initial begin
        pending_items.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(mk(-32768, -32768, 32767, 32767, 32767,
                                   32767, 32767, 32767, 32767));
        pending_items.push_back(mk(32767, 32767, 0, -32768, -32768,
                                   -32768, -32768, 32767, 32767));
        pending_items.push_back(mk(-32768, 32767, 32767, -32768, 32767,
                                   -32768, -32768, 0, 0));
        pending_items.push_back(mk(0, -20, 5, 0, 15, 0, 0, 10, 10));
        pending_items.push_back(mk(0, -20, 5, 0, 14, 0, 0, 10, 10));
        pending_items.push_back(mk(-30, 5, 3, 100, 0, 0, 0, 10, 10));
        pending_items.push_back(mk(50, 5, 3, -100, 0, 0, 0, 10, 10));
        pending_items.push_back(mk(5, 50, 3, 0, -100, 0, 0, 10, 10));
        pending_items.push_back(mk(-10, -10, 5, 100, -100, 0, 0, 10, 10));
        pending_items.push_back(mk(-10, 20, 4, 40, -40, 0, 0, 10, 10));
        pending_items.push_back(mk(-20, 0, 3, 40, 40, 0, 0, 0, 0));
        pending_items.push_back(mk(13, 5, 3, 0, 0, 0, 0, 10, 10));
        pending_items.push_back(mk(14, 5, 3, 0, 0, 0, 0, 10, 10));
        pending_items.push_back(mk(13, 14, 5, 0, 0, 0, 0, 10, 10));
        pending_items.push_back(mk(-16'sd5, 0, 0, 20, 0, 0, 0, 0, 0));
        pending_items.push_back(mk(0, -1, 0, 0, 1, -5, 0, 10, 0));
        pending_items.push_back(mk(-9, -9, 1, 30, 30, 0, 0, 0, 0));
        repeat (1500) pending_items.push_back(random_sweep());
        stim_done = 1'b1;
    end

    initial begin
        in_ch.valid = 1'b0;
        out_ch.ready = 1'b0;
        {in_ch.center_x, in_ch.center_y, in_ch.circle_radius, in_ch.move_x,
         in_ch.move_y, in_ch.box_left, in_ch.box_top, in_ch.box_width,
         in_ch.box_height} = '0;
    end

    function automatic int draw_wait();
        return $urandom_range(0, 3) == 0 ? $urandom_range(0, 19) : 0;
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_sweep s;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_wait > 0) begin
                in_wait <= in_wait - 1;
                in_ch.valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                s = pending_items.pop_front();
                expected_hits.push_back(predict_hit(s));
                in_ch.valid         <= 1'b1;
                in_ch.center_x      <= s.cx;
                in_ch.center_y      <= s.cy;
                in_ch.circle_radius <= s.r;
                in_ch.move_x        <= s.vx;
                in_ch.move_y        <= s.vy;
                in_ch.box_left      <= s.x0;
                in_ch.box_top       <= s.y0;
                in_ch.box_width     <= s.w;
                in_ch.box_height    <= s.h;
                in_wait <= draw_wait();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        logic exp_hit;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_hits.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result hit=%0b", out_ch.hit);
            end else begin
                exp_hit = expected_hits.pop_front();
                if (out_ch.hit !== exp_hit) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("hit mismatch: expected %0b got %0b", exp_hit, out_ch.hit);
                end
            end
        end
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (out_wait > 0) begin
            out_wait <= out_wait - 1;
            out_ch.ready <= 1'b0;
        end else if (!out_ch.ready || out_ch.valid) begin
            out_ch.ready <= 1'b1;
            if (out_ch.valid) out_wait <= draw_wait();
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (!(stim_done && pending_items.size() == 0 && !in_ch.valid
                 && expected_hits.size() == 0))
            @(posedge i_clk);
        repeat (shc_pkg::STAGES * 4) @(posedge i_clk);
        if (mismatches == 0 && expected_hits.size() == 0) begin
            $display("PASS swept_circle_rect_hit");
        end else begin
            $display("FAIL swept_circle_rect_hit");
        end
        $finish;
    end

    initial begin
        wait (cycle_count > 200000);
        $display("FAIL swept_circle_rect_hit");
        $finish;
    end

endmodule
